// ----- design/gtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned CfgAddrW = 2;
    localparam logic [CfgAddrW-1:0] CFG_TURN_GAIN      = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_SPEED_GAIN     = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_MIN_TURN       = 2'd2;
    localparam logic [CfgAddrW-1:0] CFG_GOAL_TOLERANCE = 2'd3;
    localparam int unsigned CfgDataW = 15;

    // Register reset values.
    localparam logic [11:0] TURN_GAIN_RST      = 12'd1280;
    localparam logic [13:0] SPEED_GAIN_RST     = 14'd2048;
    localparam logic [14:0] MIN_TURN_RST       = 15'd1024;
    localparam logic [11:0] GOAL_TOLERANCE_RST = 12'd205;

    // Angles in Q2.13 radians.
    localparam logic signed [17:0] ANG_PI      = 18'sd25736;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [16:0] ANG_HALF_PI = 17'sd12868;
    localparam int unsigned CordicSteps = 14;
    localparam int unsigned SqrtSteps   = 20;
    localparam int unsigned DivSteps    = 18;

    typedef struct packed {
        logic [14:0]        pose_x;
        logic [14:0]        pose_y;
        logic signed [15:0] pose_heading;
        logic [14:0]        target_x;
        logic [14:0]        target_y;
    } t_in;

    typedef struct packed {
        logic signed [15:0] angular_rate;
        logic [15:0]        linear_speed;
        logic               at_goal;
    } t_out;

    // Arctangent of 2^-i in Q2.13.
    function automatic logic signed [16:0] atan_entry(input int unsigned idx);
        logic signed [16:0] v;
        unique case (idx)
            0:  v = 17'sd6434;
            1:  v = 17'sd3798;
            2:  v = 17'sd2007;
            3:  v = 17'sd1019;
            4:  v = 17'sd511;
            5:  v = 17'sd256;
            6:  v = 17'sd128;
            7:  v = 17'sd64;
            8:  v = 17'sd32;
            9:  v = 17'sd16;
            10: v = 17'sd8;
            11: v = 17'sd4;
            12: v = 17'sd2;
            13: v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/go_to_goal_steering_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Go-to-goal steering controller. One pose beat enters per cycle and one
// command beat leaves per cycle while the output is not stalled. The pose
// passes through a 20-stage square root (which also carries the 14 CORDIC
// atan2 stages) followed by an 18-stage restoring divider. The whole pipeline
// holds while the output beat is stalled. Configuration registers are read by
// stages A, F and G, so write them only when the pipeline is empty.
module go_to_goal_steering_controller #(
    parameter int unsigned FRAC_BITS = 11
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  gtg_pkg::t_in                         i_data,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output gtg_pkg::t_out                        o_data,
    input  wire                                  i_cfg_we,
    input  wire  [gtg_pkg::CfgAddrW-1:0]         i_cfg_addr,
    input  wire  [gtg_pkg::CfgDataW-1:0]         i_cfg_data
);

    localparam int unsigned S   = 21 - FRAC_BITS;
    localparam int unsigned DSH = 16 - FRAC_BITS;
    localparam int unsigned DW  = 16 + DSH;
    localparam int unsigned CW  = DW + gtg_pkg::DivSteps;
    localparam int unsigned NC  = gtg_pkg::SqrtSteps;
    localparam int unsigned ND  = gtg_pkg::DivSteps;

    // Configuration registers.
    logic [11:0] r_turn_gain;
    logic [13:0] r_speed_gain;
    logic [14:0] r_min_turn;
    logic [11:0] r_goal_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain  <= gtg_pkg::TURN_GAIN_RST;
            r_speed_gain <= gtg_pkg::SPEED_GAIN_RST;
            r_min_turn   <= gtg_pkg::MIN_TURN_RST;
            r_goal_tol   <= gtg_pkg::GOAL_TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gtg_pkg::CFG_TURN_GAIN:      r_turn_gain  <= i_cfg_data[11:0];
                gtg_pkg::CFG_SPEED_GAIN:     r_speed_gain <= i_cfg_data[13:0];
                gtg_pkg::CFG_MIN_TURN:       r_min_turn   <= i_cfg_data[14:0];
                gtg_pkg::CFG_GOAL_TOLERANCE: r_goal_tol   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register can take a beat.
    logic en;
    logic r_out_vld;
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // Stage A: axis errors and the arrival test.
    logic               r_a_vld;
    logic signed [15:0] r_a_dx, r_a_dy;
    logic [14:0]        r_a_adx, r_a_ady;
    logic               r_a_goal;
    logic signed [15:0] r_a_hd;
    logic signed [15:0] n_dx, n_dy;
    logic [14:0]        n_adx, n_ady;

    always_comb begin
        n_dx  = $signed({1'b0, i_data.target_x}) - $signed({1'b0, i_data.pose_x});
        n_dy  = $signed({1'b0, i_data.target_y}) - $signed({1'b0, i_data.pose_y});
        n_adx = n_dx[15] ? 15'(-n_dx) : n_dx[14:0];
        n_ady = n_dy[15] ? 15'(-n_dy) : n_dy[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx   <= n_dx;
            r_a_dy   <= n_dy;
            r_a_adx  <= n_adx;
            r_a_ady  <= n_ady;
            r_a_goal <= (n_adx <= 15'(r_goal_tol)) && (n_ady <= 15'(r_goal_tol));
            r_a_hd   <= i_data.pose_heading;
        end
    end

    // Shared pipeline for CORDIC atan2 and the square root; element 0 is stage B.
    logic               r_vld   [0:NC];
    logic signed [35:0] r_cx    [0:NC];
    logic signed [35:0] r_cy    [0:NC];
    logic signed [16:0] r_cz    [0:NC];
    logic [39:0]        r_sv    [0:NC];
    logic [21:0]        r_srem  [0:NC];
    logic [19:0]        r_sroot [0:NC];
    logic               r_goal  [0:NC];
    logic signed [15:0] r_hd    [0:NC];

    // Stage B: left half plane pre-rotation and the squared distance.
    logic signed [15:0] n_px, n_py;
    logic signed [16:0] n_pz;
    logic [30:0]        n_d2;

    always_comb begin
        n_px = r_a_dx;
        n_py = r_a_dy;
        n_pz = '0;
        if (r_a_dx[15]) begin
            if (!r_a_dy[15]) begin
                n_px = r_a_dy;
                n_py = -r_a_dx;
                n_pz = gtg_pkg::ANG_HALF_PI;
            end else begin
                n_px = -r_a_dy;
                n_py = r_a_dx;
                n_pz = -gtg_pkg::ANG_HALF_PI;
            end
        end
        n_d2 = 31'(30'(r_a_adx) * 30'(r_a_adx)) + 31'(30'(r_a_ady) * 30'(r_a_ady));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0]    <= {{4{n_px[15]}}, n_px, 16'b0};
            r_cy[0]    <= {{4{n_py[15]}}, n_py, 16'b0};
            r_cz[0]    <= n_pz;
            r_sv[0]    <= {1'b0, n_d2, 8'b0};
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_goal[0]  <= r_a_goal;
            r_hd[0]    <= r_a_hd;
        end
    end

    // One square-root digit per stage, and one CORDIC rotation in the first 14.
    for (genvar j = 0; j < NC; j++) begin : g_step
        logic signed [35:0] xs, ys, nx, ny;
        logic signed [16:0] nz;
        logic [23:0]        rem_t, trial;
        logic [21:0]        nrem;
        logic [19:0]        nroot;

        always_comb begin
            xs = r_cx[j] >>> j;
            ys = r_cy[j] >>> j;
            nx = r_cx[j];
            ny = r_cy[j];
            nz = r_cz[j];
            if (j < gtg_pkg::CordicSteps) begin
                if (!r_cy[j][35]) begin
                    nx = r_cx[j] + ys;
                    ny = r_cy[j] - xs;
                    nz = r_cz[j] + gtg_pkg::atan_entry(j);
                end else begin
                    nx = r_cx[j] - ys;
                    ny = r_cy[j] + xs;
                    nz = r_cz[j] - gtg_pkg::atan_entry(j);
                end
            end
            rem_t = {r_srem[j], r_sv[j][39-2*j -: 2]};
            trial = {2'b0, r_sroot[j], 2'b01};
            if (rem_t >= trial) begin
                nrem  = 22'(rem_t - trial);
                nroot = {r_sroot[j][18:0], 1'b1};
            end else begin
                nrem  = rem_t[21:0];
                nroot = {r_sroot[j][18:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[j+1]    <= nx;
                r_cy[j+1]    <= ny;
                r_cz[j+1]    <= nz;
                r_sv[j+1]    <= r_sv[j];
                r_srem[j+1]  <= nrem;
                r_sroot[j+1] <= nroot;
                r_goal[j+1]  <= r_goal[j];
                r_hd[j+1]    <= r_hd[j];
            end
        end
    end

    // Stage E: heading error wrapped once.
    logic               r_e_vld, r_e_goal;
    logic signed [17:0] r_e_err;
    logic [19:0]        r_e_dist;
    logic signed [17:0] n_err;

    always_comb begin
        n_err = 18'(r_cz[NC]) - 18'(r_hd[NC]);
        if (n_err < -gtg_pkg::ANG_PI) begin
            n_err = n_err + gtg_pkg::ANG_TWO_PI;
        end else if (n_err > gtg_pkg::ANG_PI) begin
            n_err = n_err - gtg_pkg::ANG_TWO_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_vld[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_err  <= n_err;
            r_e_goal <= r_goal[NC];
            r_e_dist <= r_sroot[NC];
        end
    end

    // Stage F: rounded and saturated angular rate.
    logic               r_f_vld, r_f_goal;
    logic signed [15:0] r_f_w;
    logic [19:0]        r_f_dist;
    logic signed [31:0] n_prod, n_sh;
    logic signed [15:0] n_w;

    always_comb begin
        n_prod = 32'($signed({1'b0, r_turn_gain}) * r_e_err) + (32'sd1 <<< (S - 1));
        n_sh   = n_prod >>> S;
        if (n_sh > 32'sd32767) begin
            n_w = 16'sh7fff;
        end else if (n_sh < -32'sd32768) begin
            n_w = -16'sh8000;
        end else begin
            n_w = n_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_w    <= n_w;
            r_f_goal <= r_e_goal;
            r_f_dist <= r_e_dist;
        end
    end

    // Stage G: speed numerator and the scaled divisor; element 0 of the divider.
    logic               r_dvld [0:ND];
    logic [CW-1:0]      r_drem [0:ND];
    logic [DW-1:0]      r_dden [0:ND];
    logic [ND-1:0]      r_dq   [0:ND];
    logic               r_dgoal[0:ND];
    logic signed [15:0] r_dw   [0:ND];
    logic [15:0]        n_aw, n_div;

    always_comb begin
        n_aw  = r_f_w[15] ? 16'(-r_f_w) : 16'(r_f_w);
        n_div = (n_aw > 16'(r_min_turn)) ? n_aw : 16'(r_min_turn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else if (en) begin
            r_dvld[0] <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem[0]  <= CW'(34'(r_speed_gain) * 34'(r_f_dist));
            r_dden[0]  <= DW'(n_div) << DSH;
            r_dq[0]    <= '0;
            r_dgoal[0] <= r_f_goal;
            r_dw[0]    <= r_f_w;
        end
    end

    // Restoring divider, one quotient bit per stage from the top.
    for (genvar k = 0; k < ND; k++) begin : g_div
        localparam int unsigned B = ND - 1 - k;
        logic [CW-1:0] shd;
        logic [CW-1:0] nrem;
        logic [ND-1:0] nq;

        always_comb begin
            shd  = CW'(r_dden[k]) << B;
            nrem = r_drem[k];
            nq   = r_dq[k];
            if (r_drem[k] >= shd) begin
                nrem  = r_drem[k] - shd;
                nq[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[k+1] <= 1'b0;
            end else if (en) begin
                r_dvld[k+1] <= r_dvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[k+1]  <= nrem;
                r_dden[k+1]  <= r_dden[k];
                r_dq[k+1]    <= nq;
                r_dgoal[k+1] <= r_dgoal[k];
                r_dw[k+1]    <= r_dw[k];
            end
        end
    end

    // Output register: saturation and the at-goal override.
    gtg_pkg::t_out r_out;
    gtg_pkg::t_out n_out;

    always_comb begin
        n_out.at_goal = r_dgoal[ND];
        if (r_dgoal[ND]) begin
            n_out.angular_rate = '0;
            n_out.linear_speed = '0;
        end else begin
            n_out.angular_rate = r_dw[ND];
            n_out.linear_speed = (r_dq[ND][ND-1:16] != '0) ? 16'hffff : r_dq[ND][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dvld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // A beat that reached the goal carries no drive.
    a_goal_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.at_goal |-> o_data.angular_rate == '0 && o_data.linear_speed == '0)
        else $error("at-goal beat carries drive");

    // The input side stalls only while a finished beat is held at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output beat");

    // The output stays empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
